### rtl/core/saacc_pkg.sv
`default_nettype none
package saacc_pkg;
	localparam int unsigned DataWidth = 64;
	localparam int unsigned CntW = $clog2(DataWidth + 1);

	typedef enum logic [3:0] {
		OP_LOAD = 4'd0,
		OP_AND  = 4'd1,
		OP_OR   = 4'd2,
		OP_XOR  = 4'd3,
		OP_NOT  = 4'd4,
		OP_ADD  = 4'd5,
		OP_SUB  = 4'd6,
		OP_MUL  = 4'd7,
		OP_DIV  = 4'd8,
		OP_INC  = 4'd9,
		OP_DEC  = 4'd10
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ITER,
		ST_FIX,
		ST_DONE
	} state_t;

	localparam logic [DataWidth-1:0] MaxVal = {1'b0, {(DataWidth-1){1'b1}}};
	localparam logic [DataWidth-1:0] MinVal = {1'b1, {(DataWidth-1){1'b0}}};
endpackage
`default_nettype wire

### rtl/core/saacc_serial_unit.sv
`default_nettype none
// Shared shift-and-add multiplier / restoring divider on magnitudes, one bit per cycle.
module saacc_serial_unit import saacc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 is_div,
	input  wire logic [DataWidth-1:0] mag_a,
	input  wire logic [DataWidth-1:0] mag_b,
	output logic                      busy,
	output logic [DataWidth-1:0]      lo,
	output logic                      ovf
);
	logic [CntW-1:0]      cnt_q;
	logic                 div_q;
	logic [DataWidth-1:0] acc_q;  // product low word / quotient
	logic [DataWidth:0]   hi_q;   // product high part / remainder
	logic [DataWidth-1:0] b_q;
	logic [DataWidth:0]   sum;
	logic [DataWidth:0]   rem_sh;
	logic [DataWidth:0]   rem_sub;

	assign sum     = hi_q + (acc_q[0] ? {1'b0, b_q} : '0);
	assign rem_sh  = {hi_q[DataWidth-1:0], acc_q[DataWidth-1]};
	assign rem_sub = rem_sh - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(DataWidth);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			acc_q <= mag_a;
			hi_q  <= '0;
			b_q   <= mag_b;
		end else if (cnt_q != '0) begin
			if (div_q) begin
				if (!rem_sub[DataWidth]) begin
					hi_q <= rem_sub;
				end else begin
					hi_q <= rem_sh;
				end
				acc_q <= {acc_q[DataWidth-2:0], ~rem_sub[DataWidth]};
			end else begin
				acc_q <= {sum[0], acc_q[DataWidth-1:1]};
				hi_q  <= {1'b0, sum[DataWidth:1]};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign lo   = acc_q;
	assign ovf  = div_q ? 1'b0 : (hi_q != '0);
endmodule
`default_nettype wire

### rtl/core/saturating_alu_accumulator_unit.sv
`default_nettype none
// Saturating accumulator ALU, 64-bit signed.
// Input channel: cmd, operand, keep_result under in_valid/in_ready.
// Output channel: result under out_valid/out_ready, one beat per input beat.
// Logic, add, sub, inc, dec, load, not: the result is registered in the prepare
// state and is valid in the done state; an item passes idle, prepare, done.
// Multiply and divide: an item passes idle, prepare, iterate, fix and done; the
// product or quotient comes from the shared serial multiply/divide unit, which
// handles one bit per cycle, and is fixed up and registered in the fix state.
// One item is in flight at a time; in_ready is high in the idle state.
// A result beat holds in the output register until out_ready; while it waits
// no new item is accepted.
// keep_result writes the result into the accumulator when the result is formed.
// Reset clears the accumulator to zero and empties the output register.
module saturating_alu_accumulator_unit import saacc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  cmd,
	input  wire logic [63:0] operand,
	input  wire logic        keep_result,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      result
);
	state_t state_q, state_d;
	logic [DataWidth-1:0] acc_q, b_q, res_q;
	logic [3:0] cmd_q;
	logic keep_q, neg_q;
	logic su_start, su_busy, su_ovf;
	logic [DataWidth-1:0] su_lo, mag_a, mag_b, alu_r, fix_r;
	logic [DataWidth:0] addx, subx;
	logic a_neg, b_neg, is_div;

	assign a_neg = acc_q[DataWidth-1];
	assign b_neg = b_q[DataWidth-1];
	assign mag_a = a_neg ? (~acc_q + 1'b1) : acc_q;
	assign mag_b = b_neg ? (~b_q + 1'b1) : b_q;
	assign is_div = (cmd_q == OP_DIV);
	assign addx = {a_neg, acc_q} + {b_neg, b_q};
	assign subx = {a_neg, acc_q} - {b_neg, b_q};

	always_comb begin
		case (cmd_q)
			OP_LOAD: alu_r = b_q;
			OP_AND:  alu_r = acc_q & b_q;
			OP_OR:   alu_r = acc_q | b_q;
			OP_XOR:  alu_r = acc_q ^ b_q;
			OP_NOT:  alu_r = ~acc_q;
			OP_ADD:  alu_r = (addx[DataWidth] != addx[DataWidth-1]) ?
				(addx[DataWidth] ? MinVal : MaxVal) : addx[DataWidth-1:0];
			OP_SUB:  alu_r = (subx[DataWidth] != subx[DataWidth-1]) ?
				(subx[DataWidth] ? MinVal : MaxVal) : subx[DataWidth-1:0];
			OP_INC:  alu_r = (acc_q == MaxVal) ? acc_q : acc_q + 1'b1;
			OP_DEC:  alu_r = (acc_q == MinVal) ? acc_q : acc_q - 1'b1;
			default: alu_r = acc_q;
		endcase
	end

	always_comb begin
		if (is_div) begin
			if (b_q == '0 || (acc_q == MinVal && b_q == '1)) begin
				fix_r = MaxVal;
			end else begin
				fix_r = neg_q ? (~su_lo + 1'b1) : su_lo;
			end
		end else begin
			// product magnitude must fit below 2^(w-1), or equal it when negative
			if (su_ovf || (su_lo[DataWidth-1] &&
					!(neg_q && su_lo == MinVal))) begin
				fix_r = neg_q ? MinVal : MaxVal;
			end else begin
				fix_r = neg_q ? (~su_lo + 1'b1) : su_lo;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_PREP;
			ST_PREP: state_d = (cmd_q == OP_MUL || cmd_q == OP_DIV) ? ST_ITER : ST_DONE;
			ST_ITER: if (!su_busy) state_d = ST_FIX;
			ST_FIX:  state_d = ST_DONE;
			ST_DONE: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_DONE);
		su_start  = (state_q == ST_PREP) && (cmd_q == OP_MUL || cmd_q == OP_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
		end else begin
			state_q <= state_d;
			if (keep_q && state_q == ST_PREP && state_d == ST_DONE) acc_q <= alu_r;
			if (keep_q && state_q == ST_FIX) acc_q <= fix_r;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= cmd;
			b_q    <= operand[DataWidth-1:0];
			keep_q <= keep_result;
		end
		if (state_q == ST_PREP) begin
			neg_q <= a_neg ^ b_neg;
			res_q <= alu_r;
		end
		if (state_q == ST_FIX) res_q <= fix_r;
	end

	saacc_serial_unit u_serial (
		.clk(clk), .arst_n(arst_n), .start(su_start), .is_div(is_div),
		.mag_a(mag_a), .mag_b(mag_b), .busy(su_busy), .lo(su_lo), .ovf(su_ovf)
	);

	assign result = 64'($signed(res_q));

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept while result pending");
	a_iter_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(su_busy) |-> $past(su_start)) else $error("serial unit started unasked");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result))
		else $error("result dropped");
endmodule
`default_nettype wire
